FILE: hdl/c_comment_stripping_scanner_macros.svh
// Assertion macros for the comment stripping scanner RTL.
`ifndef C_COMMENT_STRIPPING_SCANNER_MACROS_SVH
`define C_COMMENT_STRIPPING_SCANNER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CCS_ASSERT_ALWAYS(lbl, ck, rn, expr) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (expr)) \
        else $error("ccs assertion failed");
`define CCS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("ccs assertion failed");
`else
`define CCS_ASSERT_ALWAYS(lbl, ck, rn, expr)
`define CCS_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`endif
`endif

FILE: hdl/ccs_pkg.sv
// Types, codes and helper functions for the comment stripping scanner.
package ccs_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_EOL  = 2'd1;
    localparam logic [1:0] KIND_EOF  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [1:0] OUT_CHAR   = 2'd0;
    localparam logic [1:0] OUT_EOL    = 2'd1;
    localparam logic [1:0] OUT_DIRECT = 2'd2;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [3:0] {
        MODE_NORMAL  = 4'd0,
        MODE_SLASH   = 4'd1,
        MODE_LINECMT = 4'd2,
        MODE_BLOCK   = 4'd3,
        MODE_BLKSTAR = 4'd4,
        MODE_STR     = 4'd5,
        MODE_STRESC  = 4'd6,
        MODE_CHR     = 4'd7,
        MODE_CHRESC  = 4'd8
    } mode_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] chr;
        logic       lit;
        logic       done;
        logic       last;
    } res_t;

    // Up to two result beats handed from the scanner to the queue.
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } push_t;

    typedef struct packed {
        logic  emit;
        res_t  r;
        mode_t mode;
        logic  lb;
    } step_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic res_t mk_res(input logic [1:0] k, input logic [7:0] c,
                                    input logic lit, input logic done);
        res_t r;
        r.kind = k;
        r.chr  = c;
        r.lit  = lit;
        r.done = done;
        r.last = 1'b0;
        return r;
    endfunction

    // Handle one item in ordinary code mode.
    function automatic step_t normal_step(input logic [1:0] k, input logic [7:0] c,
                                          input logic lb);
        step_t s;
        s.emit = 1'b0;
        s.r    = mk_res(OUT_CHAR, 8'd0, 1'b0, 1'b0);
        s.mode = MODE_NORMAL;
        s.lb   = lb;
        if (k == KIND_EOL || k == KIND_EOF) begin
            s.emit = 1'b1;
            s.r    = mk_res(OUT_EOL, 8'd0, 1'b0, k == KIND_EOF);
            s.lb   = 1'b1;
        end else if (c == CH_SLASH) begin
            s.mode = MODE_SLASH;
        end else if (c == CH_HASH && lb) begin
            s.emit = 1'b1;
            s.r    = mk_res(OUT_DIRECT, CH_HASH, 1'b0, 1'b0);
            s.lb   = 1'b0;
        end else begin
            s.emit = 1'b1;
            s.r    = mk_res(OUT_CHAR, c, 1'b0, 1'b0);
            if (!is_ws(c)) begin
                s.lb = 1'b0;
            end
            if (c == CH_DQUOTE) begin
                s.mode = MODE_STR;
            end else if (c == CH_SQUOTE) begin
                s.mode = MODE_CHR;
            end
        end
        return s;
    endfunction

endpackage

FILE: hdl/ccs_front.sv
// Front end: accepts input beats, tracks scan mode and builds result beats.
module ccs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        kind,
    input  logic [7:0]        char_code,
    input  logic              q_space,
    output ccs_pkg::push_t    push
);

    ccs_pkg::mode_t mode_reg, mode_next;
    logic           lb_reg, lb_next;
    ccs_pkg::step_t ns;
    ccs_pkg::res_t  r0, r1;
    logic [1:0]     cnt;
    logic           accept;
    logic           is_str;
    logic           esc;
    logic [7:0]     quote;

    assign in_ready = q_space;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ccs_pkg::MODE_NORMAL;
            lb_reg   <= 1'b1;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            lb_reg   <= lb_next;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        lb_next   = lb_reg;
        r0        = ccs_pkg::mk_res(ccs_pkg::OUT_CHAR, 8'd0, 1'b0, 1'b0);
        r1        = r0;
        cnt       = 2'd0;
        ns        = ccs_pkg::normal_step(kind, char_code, lb_reg);
        is_str    = (mode_reg == ccs_pkg::MODE_STR) || (mode_reg == ccs_pkg::MODE_STRESC);
        esc       = (mode_reg == ccs_pkg::MODE_STRESC) || (mode_reg == ccs_pkg::MODE_CHRESC);
        quote     = is_str ? ccs_pkg::CH_DQUOTE : ccs_pkg::CH_SQUOTE;
        if (kind != ccs_pkg::KIND_NONE)
        begin
            case (mode_reg)
                ccs_pkg::MODE_SLASH:
                begin
                    if (kind == ccs_pkg::KIND_CHAR && char_code == ccs_pkg::CH_SLASH)
                    begin
                        mode_next = ccs_pkg::MODE_LINECMT;
                    end
                    else if (kind == ccs_pkg::KIND_CHAR && char_code == ccs_pkg::CH_STAR)
                    begin
                        mode_next = ccs_pkg::MODE_BLOCK;
                    end
                    else
                    begin
                        // release the held slash, then treat this item as code
                        ns        = ccs_pkg::normal_step(kind, char_code, 1'b0);
                        r0        = ccs_pkg::mk_res(ccs_pkg::OUT_CHAR, ccs_pkg::CH_SLASH,
                                                    1'b0, 1'b0);
                        r1        = ns.r;
                        cnt       = ns.emit ? 2'd2 : 2'd1;
                        mode_next = ns.mode;
                        lb_next   = ns.lb;
                    end
                end
                ccs_pkg::MODE_LINECMT:
                begin
                    if (kind != ccs_pkg::KIND_CHAR)
                    begin
                        r0        = ccs_pkg::mk_res(ccs_pkg::OUT_EOL, 8'd0, 1'b0,
                                                    kind == ccs_pkg::KIND_EOF);
                        cnt       = 2'd1;
                        mode_next = ccs_pkg::MODE_NORMAL;
                        lb_next   = 1'b1;
                    end
                end
                ccs_pkg::MODE_BLOCK, ccs_pkg::MODE_BLKSTAR:
                begin
                    if (kind == ccs_pkg::KIND_EOL)
                    begin
                        r0        = ccs_pkg::mk_res(ccs_pkg::OUT_EOL, 8'd0, 1'b0, 1'b0);
                        cnt       = 2'd1;
                        mode_next = ccs_pkg::MODE_BLOCK;
                        lb_next   = 1'b1;
                    end
                    else if (kind == ccs_pkg::KIND_EOF)
                    begin
                        r0        = ccs_pkg::mk_res(ccs_pkg::OUT_EOL, 8'd0, 1'b0, 1'b1);
                        cnt       = 2'd1;
                        mode_next = ccs_pkg::MODE_NORMAL;
                        lb_next   = 1'b1;
                    end
                    else if (mode_reg == ccs_pkg::MODE_BLKSTAR &&
                             char_code == ccs_pkg::CH_SLASH)
                    begin
                        mode_next = ccs_pkg::MODE_NORMAL;
                    end
                    else if (char_code == ccs_pkg::CH_STAR)
                    begin
                        mode_next = ccs_pkg::MODE_BLKSTAR;
                    end
                    else
                    begin
                        mode_next = ccs_pkg::MODE_BLOCK;
                    end
                end
                ccs_pkg::MODE_STR, ccs_pkg::MODE_STRESC,
                ccs_pkg::MODE_CHR, ccs_pkg::MODE_CHRESC:
                begin
                    if (kind != ccs_pkg::KIND_CHAR)
                    begin
                        // line end or end of input leaves the literal open
                        r0        = ccs_pkg::mk_res(ccs_pkg::OUT_EOL, 8'd0, 1'b1,
                                                    kind == ccs_pkg::KIND_EOF);
                        cnt       = 2'd1;
                        mode_next = ccs_pkg::MODE_NORMAL;
                        lb_next   = 1'b1;
                    end
                    else
                    begin
                        r0  = ccs_pkg::mk_res(ccs_pkg::OUT_CHAR, char_code, 1'b0, 1'b0);
                        cnt = 2'd1;
                        if (esc)
                        begin
                            mode_next = is_str ? ccs_pkg::MODE_STR : ccs_pkg::MODE_CHR;
                        end
                        else if (char_code == ccs_pkg::CH_BSLASH)
                        begin
                            mode_next = is_str ? ccs_pkg::MODE_STRESC : ccs_pkg::MODE_CHRESC;
                        end
                        else if (char_code == quote)
                        begin
                            mode_next = ccs_pkg::MODE_NORMAL;
                        end
                    end
                end
                default:
                begin
                    r0        = ns.r;
                    cnt       = ns.emit ? 2'd1 : 2'd0;
                    mode_next = ns.mode;
                    lb_next   = ns.lb;
                end
            endcase
        end
        if (cnt == 2'd1)
        begin
            r0.last = 1'b1;
        end
        if (cnt == 2'd2)
        begin
            r1.last = 1'b1;
        end
        push.cnt = accept ? cnt : 2'd0;
        push.r0  = r0;
        push.r1  = r1;
    end

endmodule

FILE: hdl/ccs_queue.sv
// Short result queue: takes up to two beats per cycle, gives one.
module ccs_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ccs_pkg::push_t           push,
    output logic                     space,
    input  logic                     pop,
    output logic                     head_valid,
    output ccs_pkg::res_t            head,
    output logic [ccs_pkg::QCW-1:0]  level
);

    ccs_pkg::res_t                mem [ccs_pkg::QDEPTH];
    logic [ccs_pkg::QAW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [ccs_pkg::QAW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [ccs_pkg::QCW-1:0]      count_reg, count_next;

    assign level      = count_reg;
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    // room for a two-beat push whatever the back end does this cycle
    assign space      = (count_reg <= ccs_pkg::QCW'(ccs_pkg::QDEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + ccs_pkg::QAW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + ccs_pkg::QAW'(pop);
        count_next  = count_reg + ccs_pkg::QCW'(push.cnt) - ccs_pkg::QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2)
        begin
            mem[wr_ptr_reg + ccs_pkg::QAW'(1)] <= push.r1;
        end
    end

endmodule

FILE: hdl/ccs_back.sv
// Back end: output register that drains the queue onto the result channel.
module ccs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  ccs_pkg::res_t   head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output ccs_pkg::res_t   res
);

    logic          valid_reg, valid_next;
    ccs_pkg::res_t res_reg;

    assign pop        = head_valid && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign res        = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= head;
        end
    end

endmodule

FILE: hdl/c_comment_stripping_scanner.sv
// C comment stripping scanner: usage notes
// Input channel (in_valid/in_ready): one beat per character, line end or end of
// input, coded by kind; char_code holds the byte for ordinary characters.
// Output channel (out_valid/out_ready): result beats with out_kind, out_char,
// open_literal, stream_done and last; last marks the final result of an input.
// An input beat gives zero, one or two results. The front end takes one beat
// per cycle while the queue has space; a beat that releases a held slash gives
// two results, which the result queue absorbs.
// An accepted input beat's results are written into the queue and then into the
// output register, which drives out_valid.
// Throughput: one input beat per cycle while results drain at one per cycle;
// the four-entry queue sets how far the front end runs ahead of the output.
// When the receiver stalls, the output register holds, the queue fills, and
// in_ready drops once fewer than two entries are free.
// Reset puts the scanner in ordinary code mode at a line start and empties
// the queue. End of input also returns to that state for a new stream.
`include "c_comment_stripping_scanner_macros.svh"
module c_comment_stripping_scanner (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_kind,
    output logic [7:0] out_char,
    output logic       open_literal,
    output logic       stream_done,
    output logic       last
);

    ccs_pkg::push_t              push;
    logic                        q_space;
    logic                        pop;
    logic                        head_valid;
    ccs_pkg::res_t               head;
    ccs_pkg::res_t               res;
    logic [ccs_pkg::QCW-1:0]     level;

    ccs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .char_code (char_code),
        .q_space   (q_space),
        .push      (push)
    );

    ccs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space      (q_space),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .level      (level)
    );

    ccs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .res        (res)
    );

    assign out_kind     = res.kind;
    assign out_char     = res.chr;
    assign open_literal = res.lit;
    assign stream_done  = res.done;
    assign last         = res.last;

    `CCS_ASSERT_ALWAYS(a_queue_bound, clk, rst_n, level <= ccs_pkg::QCW'(ccs_pkg::QDEPTH))
    `CCS_ASSERT_IMPL(a_done_is_final_eol, clk, rst_n, out_valid && stream_done,
                     out_kind == ccs_pkg::OUT_EOL && last)
    `CCS_ASSERT_IMPL(a_open_lit_on_eol, clk, rst_n, out_valid && open_literal,
                     out_kind == ccs_pkg::OUT_EOL && last)
    `CCS_ASSERT_IMPL(a_two_beat_push, clk, rst_n, push.cnt == 2'd2,
                     push.r0.chr == ccs_pkg::CH_SLASH && !push.r0.last && push.r1.last)

endmodule

FILE: bench/c_strip_checker.sv
// Checker for the comment stripping scanner: predicts result beats and compares them.
module c_strip_checker
    import ccs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] kind,
    input  logic [7:0] char_code,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] out_kind,
    input  logic [7:0] out_char,
    input  logic       open_literal,
    input  logic       stream_done,
    input  logic       last,
    output int         mismatches,
    output int         outstanding,
    output int         checked
);

    mode_t scan_mode;
    logic  line_blank;
    res_t  step_q[$];
    res_t  expected_q[$];
    res_t  seen;
    res_t  want;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic void add_result(input logic [1:0] k, input logic [7:0] c,
                                       input logic lit, input logic done);
        res_t r;
        r.kind = k;
        r.chr  = c;
        r.lit  = lit;
        r.done = done;
        r.last = 1'b0;
        step_q.push_back(r);
    endfunction

    // Line end or end of input: back to code at a line start.
    function automatic void close_line(input logic lit, input logic done);
        add_result(OUT_EOL, 8'h00, lit, done);
        scan_mode  = MODE_NORMAL;
        line_blank = 1'b1;
    endfunction

    function automatic void code_item(input logic [1:0] k, input logic [7:0] c);
        if (k == KIND_EOL) begin
            close_line(1'b0, 1'b0);
        end else if (k == KIND_EOF) begin
            close_line(1'b0, 1'b1);
        end else if (c == CH_SLASH) begin
            scan_mode = MODE_SLASH;
        end else if (c == CH_HASH && line_blank) begin
            add_result(OUT_DIRECT, CH_HASH, 1'b0, 1'b0);
            line_blank = 1'b0;
        end else begin
            if (!is_blank(c)) begin
                line_blank = 1'b0;
            end
            add_result(OUT_CHAR, c, 1'b0, 1'b0);
            if (c == CH_DQUOTE) begin
                scan_mode = MODE_STR;
            end else if (c == CH_SQUOTE) begin
                scan_mode = MODE_CHR;
            end
        end
    endfunction

    function automatic void predict_beat(input logic [1:0] k, input logic [7:0] c);
        logic in_str;
        logic escaped;
        res_t r;
        step_q.delete();
        in_str  = (scan_mode == MODE_STR || scan_mode == MODE_STRESC);
        escaped = (scan_mode == MODE_STRESC || scan_mode == MODE_CHRESC);
        if (k != KIND_NONE) begin
            case (scan_mode)
                MODE_SLASH: begin
                    if (k == KIND_CHAR && c == CH_SLASH) begin
                        scan_mode = MODE_LINECMT;
                    end else if (k == KIND_CHAR && c == CH_STAR) begin
                        scan_mode = MODE_BLOCK;
                    end else begin
                        // release the held slash, then treat this beat as code
                        add_result(OUT_CHAR, CH_SLASH, 1'b0, 1'b0);
                        line_blank = 1'b0;
                        scan_mode  = MODE_NORMAL;
                        code_item(k, c);
                    end
                end
                MODE_LINECMT: begin
                    if (k == KIND_EOL) begin
                        close_line(1'b0, 1'b0);
                    end else if (k == KIND_EOF) begin
                        close_line(1'b0, 1'b1);
                    end
                end
                MODE_BLOCK, MODE_BLKSTAR: begin
                    if (k == KIND_EOL) begin
                        add_result(OUT_EOL, 8'h00, 1'b0, 1'b0);
                        line_blank = 1'b1;
                        scan_mode  = MODE_BLOCK;
                    end else if (k == KIND_EOF) begin
                        close_line(1'b0, 1'b1);
                    end else if (scan_mode == MODE_BLKSTAR && c == CH_SLASH) begin
                        scan_mode = MODE_NORMAL;
                    end else if (c == CH_STAR) begin
                        scan_mode = MODE_BLKSTAR;
                    end else begin
                        scan_mode = MODE_BLOCK;
                    end
                end
                MODE_STR, MODE_STRESC, MODE_CHR, MODE_CHRESC: begin
                    if (k == KIND_EOL) begin
                        close_line(1'b1, 1'b0);
                    end else if (k == KIND_EOF) begin
                        close_line(1'b1, 1'b1);
                    end else begin
                        add_result(OUT_CHAR, c, 1'b0, 1'b0);
                        if (escaped) begin
                            scan_mode = in_str ? MODE_STR : MODE_CHR;
                        end else if (c == CH_BSLASH) begin
                            scan_mode = in_str ? MODE_STRESC : MODE_CHRESC;
                        end else if (c == (in_str ? CH_DQUOTE : CH_SQUOTE)) begin
                            scan_mode = MODE_NORMAL;
                        end
                    end
                end
                default: begin
                    scan_mode = MODE_NORMAL;
                    code_item(k, c);
                end
            endcase
        end
        foreach (step_q[i]) begin
            r      = step_q[i];
            r.last = (i == step_q.size() - 1);
            expected_q.push_back(r);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            scan_mode   = MODE_NORMAL;
            line_blank  = 1'b1;
            expected_q.delete();
            mismatches  = 0;
            checked     = 0;
            outstanding = 0;
        end else begin
            if (out_valid && out_ready) begin
                seen.kind = out_kind;
                seen.chr  = out_char;
                seen.lit  = open_literal;
                seen.done = stream_done;
                seen.last = last;
                checked++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result beat: kind=%0d char=%h lit=%b done=%b last=%b",
                                 seen.kind, seen.chr, seen.lit, seen.done, seen.last);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d wrong: exp kind=%0d char=%h lit=%b done=%b last=%b",
                                     checked, want.kind, want.chr, want.lit, want.done,
                                     want.last);
                            $display("                  got kind=%0d char=%h lit=%b done=%b last=%b",
                                     seen.kind, seen.chr, seen.lit, seen.done, seen.last);
                        end
                    end
                end
            end
            if (in_valid && in_ready) begin
                predict_beat(kind, char_code);
            end
            outstanding = expected_q.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
// Top of the comment stripping scanner testbench: clock, reset, stimulus and verdict.
module tb_top;
    import ccs_pkg::*;

    localparam int RANDOM_BEATS = 1200;
    localparam int HOLD_CYCLES  = 200;
    localparam int QUIET_LIMIT  = 3000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] kind;
    logic [7:0] char_code;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] out_kind;
    logic [7:0] out_char;
    logic       open_literal;
    logic       stream_done;
    logic       last;

    int mismatches;
    int outstanding;
    int checked;

    int burst_left   = 0;
    int beats_sent   = 0;
    int eol_beats    = 0;
    int eof_beats    = 0;
    int idle_beats   = 0;
    int holds_done   = 0;
    int drains_done  = 0;
    int quiet_cycles = 0;
    bit hold_req     = 1'b0;

    c_comment_stripping_scanner DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_kind     (out_kind),
        .out_char     (out_char),
        .open_literal (open_literal),
        .stream_done  (stream_done),
        .last         (last)
    );

    c_strip_checker u_strip_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_kind     (out_kind),
        .out_char     (out_char),
        .open_literal (open_literal),
        .stream_done  (stream_done),
        .last         (last),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .checked      (checked)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort when no beat moves on either channel for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results pending",
                     quiet_cycles, outstanding);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: changing stall styles, plus long holds on request.
    initial begin
        int style;
        int style_left;
        int phase;
        style      = 0;
        style_left = 0;
        phase      = 0;
        out_ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            if (style_left == 0) begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(16, 96);
            end
            style_left--;
            phase++;
            case (style)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= phase[2];
            endcase
        end
    end

    task automatic send(input logic [1:0] k, input logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
            burst_left = $urandom_range(1, 48);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        kind      <= k;
        char_code <= c;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        case (k)
            KIND_NONE: idle_beats++;
            KIND_EOL:  eol_beats++;
            KIND_EOF:  eof_beats++;
            default:   ;
        endcase
        if (k != KIND_NONE) begin
            beats_sent++;
        end
    endtask

    task automatic send_char(input logic [7:0] c);
        send(KIND_CHAR, c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic drain();
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        drains_done++;
    endtask

    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 15) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    function automatic logic [7:0] word_char();
        if ($urandom_range(0, 3) == 0) begin
            return 8'($urandom_range(8'h30, 8'h39));
        end
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 5))
            0:       return 8'h09;
            1:       return 8'h0B;
            2:       return 8'h0C;
            3:       return 8'h0D;
            4:       return 8'h0A;
            default: return 8'h20;
        endcase
    endfunction

    task automatic directed_items();
        send_char(8'h20);            // blank keeps the line start
        send_char(CH_HASH);          // directive marker
        send_char(CH_HASH);          // plain text now
        send_char(8'hFF);
        send_char(8'h00);
        send(KIND_EOL, 8'hFF);
        send_text("/x");             // held slash comes out with the next char
        send_char(CH_SLASH);
        send(KIND_EOL, 8'h00);
        send_text("\"\\\"");         // escaped quote keeps the string open
        send(KIND_EOL, 8'h5A);
        send_text("'\\");
        send(KIND_EOF, 8'hA5);       // end of input right after an escape
        send_text("/**");
        send(KIND_EOL, 8'h00);
        send_text("**/#");           // star run closes, hash still at line start
        send_text("//c");
        send(KIND_EOL, 8'h00);
        send(KIND_NONE, CH_SLASH);
        send_text("/*");
        send(KIND_EOF, 8'h00);       // comment never closed
        send_char(CH_SLASH);
        send(KIND_EOF, 8'h00);
    endtask

    task automatic literal_fragment(input logic [7:0] quote);
        send_char(quote);
        repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 5) == 0) begin
                send_char(CH_BSLASH);
            end
            send_char(text_char());
        end
        case ($urandom_range(0, 11))
            0: send(KIND_EOL, 8'($urandom_range(0, 255)));
            1: begin
                send_char(CH_BSLASH);
                send(KIND_EOL, 8'($urandom_range(0, 255)));
            end
            2: send(KIND_EOF, 8'($urandom_range(0, 255)));
            default: send_char(quote);
        endcase
    endtask

    task automatic block_fragment();
        send_char(CH_SLASH);
        send_char(CH_STAR);
        repeat ($urandom_range(0, 10)) begin
            case ($urandom_range(0, 5))
                0:       send(KIND_EOL, 8'($urandom_range(0, 255)));
                1:       send_char(CH_STAR);
                2:       send_char(CH_SLASH);
                default: send_char(text_char());
            endcase
        end
        if ($urandom_range(0, 15) != 0) begin
            repeat ($urandom_range(1, 3)) send_char(CH_STAR);
            send_char(CH_SLASH);
        end else if ($urandom_range(0, 1) == 0) begin
            send(KIND_EOF, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_fragment();
        case ($urandom_range(0, 13))
            0, 1: repeat ($urandom_range(1, 6)) send_char(word_char());
            2:    repeat ($urandom_range(1, 4)) send_char(blank_char());
            3:    literal_fragment(CH_DQUOTE);
            4:    literal_fragment(CH_SQUOTE);
            5: begin
                send_char(CH_SLASH);
                send_char(CH_SLASH);
                repeat ($urandom_range(0, 6)) send_char(text_char());
                send(KIND_EOL, 8'($urandom_range(0, 255)));
            end
            6:    block_fragment();
            7, 8: begin
                send(KIND_EOL, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(0, 2)) send_char(blank_char());
                    send_char(CH_HASH);
                    repeat ($urandom_range(1, 6)) send_char(word_char());
                end
            end
            9: begin
                // lone slash followed by anything
                send_char(CH_SLASH);
                send(2'($urandom_range(0, 3)), text_char());
            end
            10:   send_char(8'($urandom_range(0, 255)));
            11:   send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            12: begin
                case ($urandom_range(0, 2))
                    0:       send_char(CH_HASH);
                    1:       send_char(CH_STAR);
                    default: send_char(CH_SLASH);
                endcase
            end
            default: begin
                if ($urandom_range(0, 3) == 0) begin
                    send(KIND_EOF, 8'($urandom_range(0, 255)));
                end else begin
                    send_char(word_char());
                end
            end
        endcase
    endtask

    // Block the receiver and keep offering beats so that the input stalls.
    task automatic hold_and_push();
        hold_req   = 1'b1;
        burst_left = 80;
        repeat (20) random_fragment();
    endtask

    initial begin
        int target;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = KIND_CHAR;
        char_code = 8'h00;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_items();
        drain();
        hold_and_push();

        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target) begin
            random_fragment();
            if (beats_sent > target - RANDOM_BEATS / 2 && drains_done < 2) begin
                drain();
                hold_and_push();
            end
        end
        send(KIND_EOF, 8'h00);
        drain();
        repeat (8) @(negedge clk);

        $display("covered %0d input beats (%0d line ends, %0d ends of input, %0d unused kind)",
                 beats_sent, eol_beats, eof_beats, idle_beats);
        $display("checked %0d result beats across %0d receiver holds and %0d full drains",
                 checked, holds_done, drains_done);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/ccs_pkg.sv
hdl/ccs_front.sv
hdl/ccs_queue.sv
hdl/ccs_back.sv
hdl/c_comment_stripping_scanner.sv
bench/c_strip_checker.sv
bench/tb_top.sv
